@@ sv/obbc_pkg.sv @@
// shared constants and types for the oriented box / circle collision pipeline
// no dependencies
package obbc_pkg;

   localparam int OBBC_TRIG_BITS = 16;
   localparam int OBBC_LATENCY = 37;

   typedef enum logic [1:0] {
      OP_BOX_BOX       = 2'd0,
      OP_BOX_CIRCLE    = 2'd1,
      OP_CIRCLE_CIRCLE = 2'd2
   } op_type;

endpackage

@@ sv/obbc_delay.sv @@
// fixed-depth delay line for pipeline alignment, advances on enable
// depends on nothing
module obbc_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

@@ sv/obbc_isqrt.sv @@
// pipelined integer square root, one result bit per stage, 32 stages
// depends on nothing
module obbc_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   localparam int STEPS = 32;

   logic [63:0] v_ff [STEPS-1];
   logic [63:0] r_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] v_prev, r_prev, trial, v_in, r_in;

      if (k == 0) begin : g_first
         assign v_prev = radicand;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[k-1];
         assign r_prev = r_ff[k-1];
      end

      always_comb begin
         trial = r_prev + BIT;
         if (v_prev >= trial) begin
            v_in = v_prev - trial;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            v_in = v_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= r_in;
         end
      end

      if (k < STEPS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               v_ff[k] <= v_in;
            end
         end
      end
   end

   assign root = r_ff[STEPS-1][31:0];

endmodule

@@ sv/obbc_qwave.sv @@
// pipelined sine of a binary angle: quadrant fold, degree-9 horner in q30,
// rounding and sign; seven register stages; uses obbc_pkg
module obbc_qwave
   import obbc_pkg::*;
#(
   parameter int TRIG_BITS = OBBC_TRIG_BITS
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [15:0]                 angle,
   output logic signed [TRIG_BITS+1:0] trig
);

   localparam logic [31:0] C1 = 32'd1686629713;
   localparam logic [31:0] C3 = 32'd693598668;
   localparam logic [31:0] C5 = 32'd85569306;
   localparam logic [31:0] C7 = 32'd5026995;
   localparam logic [31:0] C9 = 32'd172272;
   localparam int RND_SH = 30 - TRIG_BITS;
   localparam logic [32:0] HALF = 33'd1 << (29 - TRIG_BITS);
   localparam logic [32:0] ONE = 33'd1 << TRIG_BITS;

   function automatic logic [31:0] mul_q30(input logic [31:0] x, input logic [31:0] y);
      logic [63:0] prod;
      prod = 64'(x) * 64'(y);
      return prod[61:30];
   endfunction

   logic [14:0] u_in;
   logic [31:0] z_in, z2_in;
   logic [32:0] rnd, shv;
   logic [TRIG_BITS:0] mag;
   logic signed [TRIG_BITS+1:0] trig_in;

   logic [31:0] z_ff  [1:5];
   logic [31:0] z2_ff [1:4];
   logic [31:0] p_ff  [2:6];
   logic        neg_ff [1:6];
   logic signed [TRIG_BITS+1:0] trig_ff;

   always_comb begin
      u_in = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      z_in = {1'b0, u_in, 16'd0};
      z2_in = mul_q30(z_in, z_in);
      rnd = {1'b0, p_ff[6]} + HALF;
      shv = rnd >> RND_SH;
      mag = (shv > ONE) ? ONE[TRIG_BITS:0] : shv[TRIG_BITS:0];
      trig_in = neg_ff[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[1] <= z_in;
         z2_ff[1] <= z2_in;
         neg_ff[1] <= angle[15];
         p_ff[2] <= C7 - mul_q30(C9, z2_ff[1]);
         p_ff[3] <= C5 - mul_q30(p_ff[2], z2_ff[2]);
         p_ff[4] <= C3 - mul_q30(p_ff[3], z2_ff[3]);
         p_ff[5] <= C1 - mul_q30(p_ff[4], z2_ff[4]);
         p_ff[6] <= mul_q30(p_ff[5], z_ff[5]);
         trig_ff <= trig_in;
         for (int i = 2; i <= 5; i++) begin
            z_ff[i] <= z_ff[i-1];
         end
         for (int i = 2; i <= 4; i++) begin
            z2_ff[i] <= z2_ff[i-1];
         end
         for (int i = 2; i <= 6; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   assign trig = trig_ff;

endmodule

@@ sv/oriented_box_circle_collision.sv @@
// Overlap test for pairs of 2D shapes: rotated box vs box, box vs circle,
// circle vs circle. Uses obbc_pkg, obbc_qwave, obbc_isqrt and obbc_delay.
//
// One shape pair enters on the req_ channel when req_valid is high and
// req_stall is low; one rsp_hit word leaves on the rsp_ channel for every
// pair, in order. Throughput is one pair per clock unless rsp_stall holds
// the pipeline. The longest path is the 32-stage square root of the
// half-diagonal coarse check; sine/cosine take 7 stages and the
// separating axis and circle clamp math 5 more, aligned by delay lines.
// The whole pipeline advances on a single enable: while a result waits at
// the output with rsp_stall high, every stage holds and req_stall is high;
// nothing is lost or repeated. A synchronous reset clears the valid bits,
// so the pipeline comes up empty; data registers are not reset.
module oriented_box_circle_collision
   import obbc_pkg::*;
#(
   parameter int TRIG_BITS = OBBC_TRIG_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic [30:0]        req_a_scale_x,
   input  logic [30:0]        req_a_scale_y,
   input  logic [15:0]        req_a_angle,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic [30:0]        req_b_scale_x,
   input  logic [30:0]        req_b_scale_y,
   input  logic [15:0]        req_b_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit
);

   localparam int LAT = OBBC_LATENCY;
   localparam int TW = TRIG_BITS + 2;
   localparam int PW = 33 + TW;
   localparam int DW = PW + 1;
   localparam int SW = 2 * TW + 1;
   localparam int KW = TRIG_BITS + 5;
   localparam int MW = 31 + KW;
   localparam int RW = MW + 2;
   localparam int LW = DW - (TRIG_BITS - 1);
   localparam int VW = LW + 1;
   localparam logic [SW-1:0] KHALF = SW'(1) << (TRIG_BITS - 1);

   function automatic logic [KW-1:0] round_k(input logic signed [SW-1:0] d);
      logic [SW-1:0] m;
      m = d[SW-1] ? SW'(-d) : SW'(d);
      m = m + KHALF;
      return KW'(m >> TRIG_BITS);
   endfunction

   function automatic logic [VW-1:0] clamp_dist(input logic signed [LW-1:0] l,
                                                input logic [30:0] lim);
      logic signed [VW-1:0] ls, lm;
      ls = VW'(l);
      lm = $signed({{(VW - 31){1'b0}}, lim});
      if (ls > lm) begin
         return VW'(ls - lm);
      end else if (ls < -lm) begin
         return VW'(-lm - ls);
      end else begin
         return '0;
      end
   endfunction

   logic en;
   logic [LAT:0] vld_ff;

   // input register
   logic [1:0] op_ff;
   logic signed [32:0] dx_in, dy_in, dx_ff, dy_ff;
   logic [30:0] asx_ff, asy_ff, bsx_ff, bsy_ff;
   logic [15:0] aang_ff, bang_ff;

   // coarse and circle front
   logic [63:0] sa2_ff, sb2_ff;
   logic [32:0] adx_ff, ady_ff;
   logic [31:0] sc_ff;
   logic        cg_ff, cg3_ff;
   logic [63:0] hth_ff, hth3_ff, sqx_ff, sqy_ff;
   logic [64:0] dist2_ff, dist2_d;
   logic        cc_ok_ff, cc_d;
   logic [65:0] axy_d;
   logic [31:0] da, db;
   logic [32:0] s_ff;
   logic [63:0] hh_ff;
   logic [32:0] hr_ff;
   logic        guard_ff, coarse_ff;
   logic [1:0]  op_d;
   logic        hit_ff;

   // trig and axes
   logic signed [TW-1:0] ca, sa, cb, sb;
   logic signed [TW-1:0] nx [4];
   logic signed [TW-1:0] ny [4];
   logic [65:0] dxy7;
   logic signed [32:0] dx7, dy7;
   logic [123:0] scl9;
   logic [30:0] asx9, asy9, bsx9, bsy9, bsx10_ff;

   logic signed [PW-1:0] pdx_ff [4];
   logic signed [PW-1:0] pdy_ff [4];
   logic signed [2*TW-1:0] pa_ff [4][4];
   logic signed [2*TW-1:0] pb_ff [4][4];
   logic signed [DW-1:0] dot_ff [4];
   logic [KW-1:0] kua_ff [4];
   logic [KW-1:0] kva_ff [4];
   logic [KW-1:0] kub_ff [4];
   logic [KW-1:0] kvb_ff [4];
   logic [DW:0] proj_ff [4];
   logic [DW:0] proj11_ff [4];
   logic [MW-1:0] m_ff [4][4];
   logic [RW-1:0] rad_ff [4];
   logic [VW-1:0] vx_ff, vy_ff;
   logic bcg_ff;
   logic [61:0] vx2_ff, vy2_ff, rr_ff;
   logic bb_ok_ff, bc_ok_ff;
   logic [1:0] box_d;
   logic sep_in;

   assign en = !vld_ff[LAT] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT];
   assign rsp_hit = hit_ff;

   assign dx_in = {req_b_pos_x[31], req_b_pos_x} - {req_a_pos_x[31], req_a_pos_x};
   assign dy_in = {req_b_pos_y[31], req_b_pos_y} - {req_a_pos_y[31], req_a_pos_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-1:0], req_valid};
      end
   end

   // front stages
   always_ff @(posedge clock) begin
      if (en) begin
         op_ff <= req_op;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         asx_ff <= req_a_scale_x;
         asy_ff <= req_a_scale_y;
         bsx_ff <= req_b_scale_x;
         bsy_ff <= req_b_scale_y;
         aang_ff <= req_a_angle;
         bang_ff <= req_b_angle;

         sa2_ff <= 64'(asx_ff) * 64'(asx_ff) + 64'(asy_ff) * 64'(asy_ff);
         sb2_ff <= 64'(bsx_ff) * 64'(bsx_ff) + 64'(bsy_ff) * 64'(bsy_ff);
         adx_ff <= dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
         ady_ff <= dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
         sc_ff <= 32'(asx_ff) + 32'(bsx_ff);

         cg_ff <= ({adx_ff, 1'b0} <= 34'(sc_ff)) && ({ady_ff, 1'b0} <= 34'(sc_ff));
         hth_ff <= 64'(sc_ff[31:1]) * (64'(sc_ff[31:1]) + 64'(sc_ff[0]));
         sqx_ff <= 64'(adx_ff[31:0]) * 64'(adx_ff[31:0]);
         sqy_ff <= 64'(ady_ff[31:0]) * 64'(ady_ff[31:0]);

         dist2_ff <= 65'(sqx_ff) + 65'(sqy_ff);
         cg3_ff <= cg_ff;
         hth3_ff <= hth_ff;

         cc_ok_ff <= cg3_ff && (dist2_ff <= 65'(hth3_ff));
      end
   end

   obbc_isqrt u_sqrt_a (.clock(clock), .en(en), .radicand(sa2_ff), .root(da));
   obbc_isqrt u_sqrt_b (.clock(clock), .en(en), .radicand(sb2_ff), .root(db));

   obbc_delay #(.WIDTH(66), .DEPTH(33)) u_dly_abs (
      .clock(clock), .en(en), .din({adx_ff, ady_ff}), .dout(axy_d)
   );
   obbc_delay #(.WIDTH(65), .DEPTH(32)) u_dly_dist (
      .clock(clock), .en(en), .din(dist2_ff), .dout(dist2_d)
   );
   obbc_delay #(.WIDTH(1), .DEPTH(32)) u_dly_cc (
      .clock(clock), .en(en), .din(cc_ok_ff), .dout(cc_d)
   );
   obbc_delay #(.WIDTH(2), .DEPTH(36)) u_dly_op (
      .clock(clock), .en(en), .din(op_ff), .dout(op_d)
   );

   // coarse check tail
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= 33'(da) + 33'(db);
         hh_ff <= 64'(s_ff[32:1]) * 64'(s_ff[32:1]);
         hr_ff <= s_ff[0] ? 33'(s_ff[32:1]) + 33'd1 : '0;
         guard_ff <= ({axy_d[65:33], 1'b0} >= {1'b0, s_ff}) ||
                     ({axy_d[32:0], 1'b0} >= {1'b0, s_ff});
         coarse_ff <= !guard_ff && (dist2_d < 65'(hh_ff) + 65'(hr_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unique case (op_d)
            OP_BOX_BOX:       hit_ff <= coarse_ff && box_d[1];
            OP_BOX_CIRCLE:    hit_ff <= coarse_ff && box_d[0];
            OP_CIRCLE_CIRCLE: hit_ff <= cc_d;
            default:          hit_ff <= 1'b0;
         endcase
      end
   end

   // sine and cosine of both angles
   obbc_qwave #(.TRIG_BITS(TRIG_BITS)) u_sin_a (
      .clock(clock), .en(en), .angle(aang_ff), .trig(sa)
   );
   obbc_qwave #(.TRIG_BITS(TRIG_BITS)) u_cos_a (
      .clock(clock), .en(en), .angle(16'(aang_ff + 16'h4000)), .trig(ca)
   );
   obbc_qwave #(.TRIG_BITS(TRIG_BITS)) u_sin_b (
      .clock(clock), .en(en), .angle(bang_ff), .trig(sb)
   );
   obbc_qwave #(.TRIG_BITS(TRIG_BITS)) u_cos_b (
      .clock(clock), .en(en), .angle(16'(bang_ff + 16'h4000)), .trig(cb)
   );

   obbc_delay #(.WIDTH(66), .DEPTH(7)) u_dly_d (
      .clock(clock), .en(en), .din({dx_ff, dy_ff}), .dout(dxy7)
   );
   obbc_delay #(.WIDTH(124), .DEPTH(9)) u_dly_scale (
      .clock(clock), .en(en), .din({asx_ff, asy_ff, bsx_ff, bsy_ff}), .dout(scl9)
   );

   assign dx7 = $signed(dxy7[65:33]);
   assign dy7 = $signed(dxy7[32:0]);
   assign asx9 = scl9[123:93];
   assign asy9 = scl9[92:62];
   assign bsx9 = scl9[61:31];
   assign bsy9 = scl9[30:0];

   // edge axes: both edges of box a, then both of box b
   always_comb begin
      nx[0] = ca;
      ny[0] = sa;
      nx[1] = -sa;
      ny[1] = ca;
      nx[2] = cb;
      ny[2] = sb;
      nx[3] = -sb;
      ny[3] = cb;
   end

   // separating axis and circle clamp stages
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            pdx_ff[i] <= PW'(dx7) * PW'(nx[i]);
            pdy_ff[i] <= PW'(dy7) * PW'(ny[i]);
            pa_ff[i][0] <= (2*TW)'(ca) * (2*TW)'(nx[i]);
            pa_ff[i][1] <= (2*TW)'(sa) * (2*TW)'(ny[i]);
            pa_ff[i][2] <= (2*TW)'(sa) * (2*TW)'(nx[i]);
            pa_ff[i][3] <= (2*TW)'(ca) * (2*TW)'(ny[i]);
            pb_ff[i][0] <= (2*TW)'(cb) * (2*TW)'(nx[i]);
            pb_ff[i][1] <= (2*TW)'(sb) * (2*TW)'(ny[i]);
            pb_ff[i][2] <= (2*TW)'(sb) * (2*TW)'(nx[i]);
            pb_ff[i][3] <= (2*TW)'(cb) * (2*TW)'(ny[i]);

            dot_ff[i] <= DW'(pdx_ff[i]) + DW'(pdy_ff[i]);
            kua_ff[i] <= round_k(SW'(pa_ff[i][0]) + SW'(pa_ff[i][1]));
            kva_ff[i] <= round_k(SW'(pa_ff[i][3]) - SW'(pa_ff[i][2]));
            kub_ff[i] <= round_k(SW'(pb_ff[i][0]) + SW'(pb_ff[i][1]));
            kvb_ff[i] <= round_k(SW'(pb_ff[i][3]) - SW'(pb_ff[i][2]));

            proj_ff[i] <= dot_ff[i][DW-1] ? {DW'(-dot_ff[i]), 1'b0} : {DW'(dot_ff[i]), 1'b0};
            m_ff[i][0] <= MW'(asx9) * MW'(kua_ff[i]);
            m_ff[i][1] <= MW'(asy9) * MW'(kva_ff[i]);
            m_ff[i][2] <= MW'(bsx9) * MW'(kub_ff[i]);
            m_ff[i][3] <= MW'(bsy9) * MW'(kvb_ff[i]);

            rad_ff[i] <= RW'(m_ff[i][0]) + RW'(m_ff[i][1]) + RW'(m_ff[i][2]) +
                         RW'(m_ff[i][3]);
            proj11_ff[i] <= proj_ff[i];
         end

         vx_ff <= clamp_dist(LW'(dot_ff[0] >>> (TRIG_BITS - 1)), asx9);
         vy_ff <= clamp_dist(LW'(dot_ff[1] >>> (TRIG_BITS - 1)), asy9);
         bsx10_ff <= bsx9;

         bcg_ff <= (vx_ff <= VW'(bsx10_ff)) && (vy_ff <= VW'(bsx10_ff));
         vx2_ff <= 62'(vx_ff[30:0]) * 62'(vx_ff[30:0]);
         vy2_ff <= 62'(vy_ff[30:0]) * 62'(vy_ff[30:0]);
         rr_ff <= 62'(bsx10_ff) * 62'(bsx10_ff);

         bb_ok_ff <= !sep_in;
         bc_ok_ff <= bcg_ff && (63'(vx2_ff) + 63'(vy2_ff) <= 63'(rr_ff));
      end
   end

   always_comb begin
      sep_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (64'(proj11_ff[i]) > 64'(rad_ff[i])) begin
            sep_in = 1'b1;
         end
      end
   end

   obbc_delay #(.WIDTH(2), .DEPTH(24)) u_dly_box (
      .clock(clock), .en(en), .din({bb_ok_ff, bc_ok_ff}), .dout(box_d)
   );

endmodule

@@ sim/tb.sv @@
// testbench for oriented_box_circle_collision: random and directed shape pairs
// checked against an in-bench overlap predictor, with bursty input and output stalls
// depends on obbc_pkg and the rtl under sv/
module tb
   import obbc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] a_pos_x;
      logic signed [31:0] a_pos_y;
      logic [30:0]        a_scale_x;
      logic [30:0]        a_scale_y;
      logic [15:0]        a_angle;
      logic signed [31:0] b_pos_x;
      logic signed [31:0] b_pos_y;
      logic [30:0]        b_scale_x;
      logic [30:0]        b_scale_y;
      logic [15:0]        b_angle;
   } pair_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = '0;
   logic signed [31:0] req_a_pos_x = '0;
   logic signed [31:0] req_a_pos_y = '0;
   logic [30:0]        req_a_scale_x = '0;
   logic [30:0]        req_a_scale_y = '0;
   logic [15:0]        req_a_angle = '0;
   logic signed [31:0] req_b_pos_x = '0;
   logic signed [31:0] req_b_pos_y = '0;
   logic [30:0]        req_b_scale_x = '0;
   logic [30:0]        req_b_scale_y = '0;
   logic [15:0]        req_b_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_hit;

   pair_type pending_pairs[$];
   bit       expected_hits[$];
   int       cycle_count = 0;
   int       error_count = 0;

   oriented_box_circle_collision DUT (.*);

   always #1 clock = ~clock;

   function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint quarter_sine(longint unsigned u);
      longint unsigned z, z2, p;
      z = u << 16;
      z2 = (z * z) >> 30;
      p = 64'd172272;
      p = 64'd5026995 - ((p * z2) >> 30);
      p = 64'd85569306 - ((p * z2) >> 30);
      p = 64'd693598668 - ((p * z2) >> 30);
      p = 64'd1686629713 - ((p * z2) >> 30);
      p = (p * z) >> 30;
      p = (p + (64'd1 << (29 - OBBC_TRIG_BITS))) >> (30 - OBBC_TRIG_BITS);
      if (p > (64'd1 << OBBC_TRIG_BITS)) p = 64'd1 << OBBC_TRIG_BITS;
      return longint'(p);
   endfunction

   function automatic longint angle_sine(logic [15:0] a);
      logic [1:0] q;
      longint unsigned f;
      longint v;
      q = a[15:14];
      f = 64'(a[13:0]);
      v = quarter_sine(q[0] ? 16384 - f : f);
      return q[1] ? -v : v;
   endfunction

   function automatic longint angle_cosine(logic [15:0] a);
      return angle_sine(a + 16'd16384);
   endfunction

   function automatic bit diagonals_overlap(longint dx, longint dy, longint unsigned asx,
         longint unsigned asy, longint unsigned bsx, longint unsigned bsy);
      longint unsigned s, ax, ay, h, r;
      s = int_sqrt(asx * asx + asy * asy) + int_sqrt(bsx * bsx + bsy * bsy);
      ax = mag(dx);
      ay = mag(dy);
      h = s >> 1;
      r = s & 1;
      if (2 * ax >= s || 2 * ay >= s) return 0;
      return ax * ax + ay * ay < h * h + h * r + r;
   endfunction

   function automatic longint proj_len(longint dot);
      return longint'((mag(dot) + (64'd1 << (OBBC_TRIG_BITS - 1))) >> OBBC_TRIG_BITS);
   endfunction

   function automatic longint half_span(longint sx, longint sy, longint c, longint s,
         longint nx, longint ny);
      return sx * proj_len(c * nx + s * ny) + sy * proj_len(-s * nx + c * ny);
   endfunction

   function automatic longint clamp_to(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic bit predict_overlap(pair_type p);
      longint dx, dy, asx, asy, bsx, bsy, ca, sa, cb, sb, lx, ly, span;
      longint nx[4], ny[4];
      longint unsigned proj, vx, vy, r, s, adx, ady, h, odd;
      bit hit;
      dx = longint'(p.b_pos_x) - longint'(p.a_pos_x);
      dy = longint'(p.b_pos_y) - longint'(p.a_pos_y);
      asx = longint'(p.a_scale_x);
      asy = longint'(p.a_scale_y);
      bsx = longint'(p.b_scale_x);
      bsy = longint'(p.b_scale_y);
      hit = 0;
      case (p.op)
         OP_BOX_BOX: begin
            if (diagonals_overlap(dx, dy, asx, asy, bsx, bsy)) begin
               ca = angle_cosine(p.a_angle);
               sa = angle_sine(p.a_angle);
               cb = angle_cosine(p.b_angle);
               sb = angle_sine(p.b_angle);
               nx = '{ca, -sa, cb, -sb};
               ny = '{sa, ca, sb, cb};
               hit = 1;
               for (int i = 0; i < 4; i++) begin
                  proj = mag(2 * (dx * nx[i] + dy * ny[i]));
                  span = half_span(asx, asy, ca, sa, nx[i], ny[i]) +
                         half_span(bsx, bsy, cb, sb, nx[i], ny[i]);
                  if (proj > unsigned'(span)) hit = 0;
               end
            end
         end
         OP_BOX_CIRCLE: begin
            if (diagonals_overlap(dx, dy, asx, asy, bsx, bsy)) begin
               ca = angle_cosine(p.a_angle);
               sa = angle_sine(p.a_angle);
               lx = (dx * ca + dy * sa) >>> (OBBC_TRIG_BITS - 1);
               ly = (dy * ca - dx * sa) >>> (OBBC_TRIG_BITS - 1);
               vx = mag(lx - clamp_to(lx, asx));
               vy = mag(ly - clamp_to(ly, asy));
               r = bsx;
               if (vx <= r && vy <= r) hit = vx * vx + vy * vy <= r * r;
            end
         end
         OP_CIRCLE_CIRCLE: begin
            s = asx + bsx;
            adx = mag(dx);
            ady = mag(dy);
            h = s >> 1;
            odd = s & 1;
            if (2 * adx <= s && 2 * ady <= s) hit = adx * adx + ady * ady <= h * h + h * odd;
         end
         default: hit = 0;
      endcase
      return hit;
   endfunction

   function automatic pair_type make_pair(logic [1:0] op, int ax, int ay, int asx, int asy,
         int aang, int bx, int by, int bsx, int bsy, int bang);
      pair_type p;
      p.op = op;
      p.a_pos_x = ax;
      p.a_pos_y = ay;
      p.a_scale_x = 31'(asx);
      p.a_scale_y = 31'(asy);
      p.a_angle = 16'(aang);
      p.b_pos_x = bx;
      p.b_pos_y = by;
      p.b_scale_x = 31'(bsx);
      p.b_scale_y = 31'(bsy);
      p.b_angle = 16'(bang);
      return p;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int unsigned sel, mask;
      int k;
      sel = $urandom_range(0, 9);
      p.op = sel < 3 ? OP_BOX_BOX : sel < 6 ? OP_BOX_CIRCLE : sel < 9 ? OP_CIRCLE_CIRCLE :
             OP_RESERVED;
      p.a_angle = 16'($urandom);
      p.b_angle = 16'($urandom);
      p.a_pos_x = $urandom;
      p.a_pos_y = $urandom;
      if ($urandom_range(0, 4) == 0) begin
         p.op = 2'($urandom);
         p.a_scale_x = 31'($urandom);
         p.a_scale_y = 31'($urandom);
         p.b_scale_x = 31'($urandom);
         p.b_scale_y = 31'($urandom);
         p.b_pos_x = $urandom;
         p.b_pos_y = $urandom;
      end else begin
         k = $urandom_range(2, 30);
         mask = (32'd1 << k) - 1;
         p.a_scale_x = 31'($urandom & mask);
         p.a_scale_y = 31'($urandom & mask);
         p.b_scale_x = 31'($urandom & mask);
         p.b_scale_y = 31'($urandom & mask);
         p.b_pos_x = p.a_pos_x + int'($urandom & mask) - int'(mask >> 1);
         p.b_pos_y = p.a_pos_y + int'($urandom & mask) - int'(mask >> 1);
      end
      return p;
   endfunction

   // driver: bursts with random gaps, payload held while stalled
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_hits.push_back(predict_overlap(pending_pairs[0]));
            void'(pending_pairs.pop_front());
         end
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_pairs.size() > 0) begin
            req_valid <= 1'b1;
            req_op <= pending_pairs[0].op;
            req_a_pos_x <= pending_pairs[0].a_pos_x;
            req_a_pos_y <= pending_pairs[0].a_pos_y;
            req_a_scale_x <= pending_pairs[0].a_scale_x;
            req_a_scale_y <= pending_pairs[0].a_scale_y;
            req_a_angle <= pending_pairs[0].a_angle;
            req_b_pos_x <= pending_pairs[0].b_pos_x;
            req_b_pos_y <= pending_pairs[0].b_pos_y;
            req_b_scale_x <= pending_pairs[0].b_scale_x;
            req_b_scale_y <= pending_pairs[0].b_scale_y;
            req_b_angle <= pending_pairs[0].b_angle;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 30);
               gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   int stall_mode = 0;
   int rx_cycles = 0;
   always @(posedge clock) begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
      if (rx_cycles >= 400 && rx_cycles < 700)
         rsp_stall <= 1'b1;
      else if (stall_mode == 0)
         rsp_stall <= 1'b0;
      else if (stall_mode == 1)
         rsp_stall <= $urandom_range(0, 2) == 0;
      else
         rsp_stall <= $urandom_range(0, 3) != 0;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected word: hit actual %0d", rsp_hit);
            error_count++;
         end else begin
            if (rsp_hit !== expected_hits[0]) begin
               $error("hit mismatch: expected %0d actual %0d", expected_hits[0], rsp_hit);
               error_count++;
            end
            void'(expected_hits.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      pending_pairs.push_back(make_pair(OP_BOX_BOX, 0, 0, 65536, 65536, 0,
                                        32768, 0, 65536, 65536, 16384));
      pending_pairs.push_back(make_pair(OP_BOX_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(OP_BOX_BOX, 100, 100, 65536, 131072, 8192,
                                        150000, 0, 65536, 65536, 65535));
      pending_pairs.push_back(make_pair(OP_BOX_BOX, 0, 0, 32'h7fffffff, 32'h7fffffff, 32768,
                                        0, 0, 32'h7fffffff, 32'h7fffffff, 49152));
      pending_pairs.push_back(make_pair(OP_BOX_BOX, 32'h80000000, 32'h80000000, 1000, 1000,
                                        0, 32'h7fffffff, 32'h7fffffff, 1000, 1000, 0));
      pending_pairs.push_back(make_pair(OP_BOX_CIRCLE, 0, 0, 65536, 65536, 0,
                                        98304, 0, 65536, 0, 0));
      pending_pairs.push_back(make_pair(OP_BOX_CIRCLE, 0, 0, 65536, 65536, 8192,
                                        131072, 131072, 65536, 65536, 0));
      pending_pairs.push_back(make_pair(OP_BOX_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(OP_BOX_CIRCLE, 0, 0, 32'h7fffffff, 32'h7fffffff,
                                        65535, 1, -1, 32'h7fffffff, 32'h7fffffff, 65535));
      pending_pairs.push_back(make_pair(OP_CIRCLE_CIRCLE, 0, 0, 65536, 0, 0,
                                        65536, 0, 65536, 0, 0));
      pending_pairs.push_back(make_pair(OP_CIRCLE_CIRCLE, 0, 0, 65536, 0, 0,
                                        65537, 0, 65536, 0, 0));
      pending_pairs.push_back(make_pair(OP_CIRCLE_CIRCLE, 0, 0, 3, 0, 0, 1, 1, 0, 0, 0));
      pending_pairs.push_back(make_pair(OP_CIRCLE_CIRCLE, 32'h80000000, 0, 32'h7fffffff, 0,
                                        0, 32'h7fffffff, 0, 32'h7fffffff, 0, 0));
      pending_pairs.push_back(make_pair(OP_CIRCLE_CIRCLE, 5, 5, 0, 0, 0, 5, 5, 0, 0, 0));
      pending_pairs.push_back(make_pair(OP_RESERVED, 0, 0, 65536, 65536, 0,
                                        0, 0, 65536, 65536, 0));
      pending_pairs.push_back(make_pair(OP_RESERVED, -1, -1, 32'h7fffffff, 32'h7fffffff,
                                        65535, -1, -1, 32'h7fffffff, 32'h7fffffff, 65535));
      repeat (500) pending_pairs.push_back(random_pair());
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_pairs.size() > 0 || expected_hits.size() > 0) @(posedge clock);
      repeat (OBBC_LATENCY + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
